// File: rtl/fpr_pkg.sv
// Shared types and constants of the FIFO page replacement block.
package fpr_pkg;

  // Result codes
  typedef enum logic [2:0] {
    OUT_INVALID  = 3'd0,
    OUT_HIT      = 3'd1,
    OUT_FILLED   = 3'd2,
    OUT_REPLACED = 3'd3,
    OUT_FLUSHED  = 3'd4
  } outcome_t;

  // Configuration register indexes
  localparam logic [1:0] REG_LOCAL_MODE    = 2'd0;
  localparam logic [1:0] REG_TOTAL_FRAMES  = 2'd1;
  localparam logic [1:0] REG_ALLOC_PERCENT = 2'd2;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 7;

  // Item kinds
  localparam logic KIND_ACCESS = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  // floor(x / 100) for x below 2**14 as (x * 5243) >> 19
  localparam int           DIV100_SHIFT = 19;
  localparam logic [12:0]  DIV100_MUL   = 13'd5243;

endpackage

// File: rtl/fpr_in_if.sv
// Input channel: page access or flush items.
interface fpr_in_if #(
  parameter int PID_BITS  = 16,
  parameter int PAGE_BITS = 12
);
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [PID_BITS-1:0]  proc_id;
  logic [PAGE_BITS-1:0] page_no;
  logic [PAGE_BITS-1:0] page_count;

  modport source (output valid, kind, proc_id, page_no, page_count, input ready);
  modport sink   (input valid, kind, proc_id, page_no, page_count, output ready);
endinterface

// File: rtl/fpr_out_if.sv
// Output channel: one result per item.
interface fpr_out_if #(
  parameter int PID_BITS  = 16,
  parameter int PAGE_BITS = 12
);
  import fpr_pkg::*;

  logic                 valid;
  logic                 ready;
  outcome_t             outcome;
  logic [PID_BITS-1:0]  evicted_proc;
  logic [PAGE_BITS-1:0] evicted_page;
  logic [31:0]          replace_total;

  modport source (output valid, outcome, evicted_proc, evicted_page, replace_total,
                  input ready);
  modport sink   (input valid, outcome, evicted_proc, evicted_page, replace_total,
                  output ready);
endinterface

// File: rtl/fpr_cfg_if.sv
// Configuration write channel.
interface fpr_cfg_if;
  import fpr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/fifo_page_replacement.sv
// FIFO page replacement: resident set in a tag memory scanned one frame a cycle.
// Steps: a flush or an out-of-range page goes straight to the finishing step; an
// access passes multiply, divide, scan (one tag compare per resident frame), evict.
// Throughput: one item at a time; the next transfer is taken the cycle after the
// result is registered, and an untaken result holds the finishing step.
// Reset (rst, synchronous): empty set, zero count, local_mode 0, 64 frames, 100%.
module fifo_page_replacement #(
  parameter int MAX_FRAMES = 64,
  parameter int PAGE_BITS  = 12,
  parameter int PID_BITS   = 16
) (
  input  logic clk,
  input  logic rst,
  fpr_in_if.sink    item,
  fpr_out_if.source result,
  fpr_cfg_if.sink   cfg
);
  import fpr_pkg::*;

  localparam int IW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW   = $clog2(MAX_FRAMES + 1);
  localparam int TW   = PID_BITS + PAGE_BITS;
  localparam int CMPW = ((PAGE_BITS > 12) ? PAGE_BITS : 12) + 1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MUL    = 6'b000010,
    S_DIV    = 6'b000100,
    S_SCAN   = 6'b001000,
    S_EVICT  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] a,
                                             input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(MAX_FRAMES)) begin
      s = s - (CW+1)'(MAX_FRAMES);
    end
    return IW'(s);
  endfunction

  state_t state;

  // Configuration
  logic       local_mode;
  logic [6:0] total_frames;
  logic [6:0] alloc_percent;

  // Resident set
  logic [TW-1:0] tag_mem [MAX_FRAMES];
  logic [TW-1:0] mem_q;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] oldest;
  logic [CW-1:0] used;
  logic [31:0]   replacements;

  // Current item
  logic                 item_kind;
  logic                 item_invalid;
  logic [PID_BITS-1:0]  item_pid;
  logic [PAGE_BITS-1:0] item_page;
  logic [PAGE_BITS-1:0] item_count;

  // Sequencer working registers
  logic [13:0]   prod;
  logic [CW-1:0] cap;
  logic [CW-1:0] issue_cnt;
  logic          pend;
  logic          hit;

  // Output register
  logic                 out_valid;
  outcome_t             out_outcome;
  logic [PID_BITS-1:0]  out_pid;
  logic [PAGE_BITS-1:0] out_page;

  logic          in_fire;
  logic          finish_go;
  logic          do_store;
  logic          do_replace;
  logic [IW-1:0] wr_addr;
  logic [26:0]   prod_scaled;
  logic [7:0]    quot;
  logic [CMPW-1:0] cap_raw;
  logic [CMPW-1:0] cap_clamp;
  logic          tag_match;

  assign item.ready = (state == S_IDLE);
  assign in_fire    = item.valid && item.ready;
  assign cfg.ready  = 1'b1;

  assign result.valid         = out_valid;
  assign result.outcome       = out_outcome;
  assign result.evicted_proc  = out_pid;
  assign result.evicted_page  = out_page;
  assign result.replace_total = replacements;

  // Capacity: min(total*percent/100, page count) if local, else total; clamped to frames
  assign prod_scaled = 27'(prod) * 27'(DIV100_MUL);
  assign quot        = prod_scaled[26:DIV100_SHIFT];
  always_comb begin
    if (local_mode) begin
      cap_raw = (CMPW'(quot) < CMPW'(item_count)) ? CMPW'(quot) : CMPW'(item_count);
    end else begin
      cap_raw = CMPW'(total_frames);
    end
    cap_clamp = (cap_raw > CMPW'(MAX_FRAMES)) ? CMPW'(MAX_FRAMES) : cap_raw;
  end

  assign tag_match = (mem_q[PAGE_BITS-1:0] == item_page) &&
                     (local_mode || (mem_q[TW-1:PAGE_BITS] == item_pid));

  assign finish_go  = (state == S_FINISH) && !(out_valid && !result.ready);
  assign do_store   = (item_kind == KIND_ACCESS) && !item_invalid && !hit &&
                      (cap != '0);
  assign do_replace = do_store && (used >= cap);
  assign wr_addr    = ring_add(oldest, used);

  // Read port: window scan, then the oldest frame for a possible eviction
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = oldest;
    if (state == S_SCAN && issue_cnt != used) begin
      rd_en   = 1'b1;
      rd_addr = ring_add(oldest, issue_cnt);
    end else if (state == S_EVICT) begin
      rd_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= tag_mem[rd_addr];
    end
    if (finish_go && do_store) begin
      tag_mem[wr_addr] <= {item_pid, item_page};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      local_mode    <= 1'b0;
      total_frames  <= 7'd64;
      alloc_percent <= 7'd100;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_LOCAL_MODE:    local_mode    <= cfg.data[0];
        REG_TOTAL_FRAMES:  total_frames  <= cfg.data;
        REG_ALLOC_PERCENT: alloc_percent <= cfg.data;
        default: ;
      endcase
    end
  end

  // Item registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_kind    <= item.kind;
      item_pid     <= item.proc_id;
      item_page    <= item.page_no;
      item_count   <= item.page_count;
      item_invalid <= (item.page_no == '0) || (item.page_no > item.page_count);
    end
    if (state == S_MUL) begin
      prod <= 14'(total_frames) * 14'(alloc_percent);
    end
    if (state == S_DIV) begin
      cap <= CW'(cap_clamp);
    end
    if (finish_go) begin
      if (do_replace) begin
        out_pid  <= mem_q[TW-1:PAGE_BITS];
        out_page <= mem_q[PAGE_BITS-1:0];
      end else begin
        out_pid  <= '0;
        out_page <= '0;
      end
      if (item_kind == KIND_FLUSH) begin
        out_outcome <= OUT_FLUSHED;
      end else if (item_invalid) begin
        out_outcome <= OUT_INVALID;
      end else if (hit) begin
        out_outcome <= OUT_HIT;
      end else if (do_replace) begin
        out_outcome <= OUT_REPLACED;
      end else begin
        out_outcome <= OUT_FILLED;
      end
    end
  end

  // Sequencer and resident set control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      oldest       <= '0;
      used         <= '0;
      replacements <= '0;
      issue_cnt    <= '0;
      pend         <= 1'b0;
      hit          <= 1'b0;
    end else begin
      if (finish_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            hit       <= 1'b0;
            pend      <= 1'b0;
            issue_cnt <= '0;
            if (item.kind == KIND_FLUSH || item.page_no == '0 ||
                item.page_no > item.page_count) begin
              state <= S_FINISH;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: state <= S_DIV;
        S_DIV: state <= S_SCAN;
        S_SCAN: begin
          pend <= rd_en;
          if (rd_en) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (pend && tag_match) begin
            hit <= 1'b1;
          end
          if (!rd_en && !pend) begin
            state <= S_EVICT;
          end
        end
        S_EVICT: state <= S_FINISH;
        S_FINISH: begin
          if (finish_go) begin
            state <= S_IDLE;
            if (item_kind == KIND_FLUSH) begin
              if (local_mode) begin
                oldest <= '0;
                used   <= '0;
              end
            end else if (do_replace) begin
              oldest       <= ring_add(oldest, CW'(1));
              replacements <= replacements + 32'd1;
            end else if (do_store) begin
              used <= used + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
